/* hw/rtl/trimmed_mean_filter_assert.svh */
// Assertion macros for the trimmed mean filter checker
`ifndef TRIMMED_MEAN_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_FILTER_ASSERT_SVH
// Checked at every rising edge outside reset
`define TMF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included
`define TMF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/tmf_pkg.sv */
// Shared constants and types of the trimmed mean filter
package tmf_pkg;
  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 40;
  localparam int FRAC_W   = 8;
  localparam int SUM_W    = 42;
  localparam int DVD_W    = SUM_W + FRAC_W;
  localparam int DIV_W    = 11;
  localparam int STORE_W  = SAMPLE_W + 1;

  localparam int BATCH_SIZE_DEF = 64;
  localparam int SKIP_COUNT_DEF = 2;
  localparam int TRIM_COUNT_DEF = 4;

  typedef enum logic [2:0] {
    S_IN, S_SWEEP, S_LAST, S_MARK, S_DIV, S_WAIT
  } state_t;
endpackage

/* hw/rtl/tmf_mem.sv */
// Sample store: one write port, one registered read port
module tmf_mem #(
  parameter int DEPTH = tmf_pkg::BATCH_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tmf_pkg::STORE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [tmf_pkg::STORE_W-1:0] rdata
);
  logic [tmf_pkg::STORE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/tmf_div.sv */
// Divider by a fixed divisor: reciprocal multiply, one partial product per cycle into an accumulator
module tmf_div #(
  parameter int DIVISOR = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tmf_pkg::DVD_W-1:0] dividend,
  output logic                      done,
  output logic [tmf_pkg::MEAN_W-1:0] quotient
);
  localparam int N_W   = tmf_pkg::DVD_W;
  localparam int L     = $clog2(DIVISOR);
  localparam int SHIFT = N_W + L;
  localparam int M_W   = N_W + 1;
  localparam int P_W   = N_W + M_W;
  localparam int NLO_W = N_W / 2;
  localparam int NHI_W = N_W - NLO_W;
  localparam int MLO_W = (M_W + 1) / 2;
  localparam int MHI_W = M_W - MLO_W;
  localparam int PT_W  = NHI_W + MLO_W;
  // ceil(2^SHIFT / DIVISOR) gives the exact floor for every dividend below 2^N_W
  localparam longint unsigned M_VAL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [M_W-1:0] M = M_W'(M_VAL);

  logic             busy;
  logic [1:0]       step;
  logic [N_W-1:0]   num;
  logic [P_W-1:0]   acc;
  logic [NHI_W-1:0] n_op;
  logic [MLO_W-1:0] m_op;
  logic [PT_W-1:0]  part;
  logic [P_W-1:0]   part_sh;

  // step bit 1 picks the dividend half, bit 0 the reciprocal half
  always_comb begin
    n_op = step[1] ? num[N_W-1:NLO_W] : NHI_W'(num[NLO_W-1:0]);
    m_op = step[0] ? MLO_W'(M[M_W-1:MLO_W]) : M[MLO_W-1:0];
    part = PT_W'(n_op) * PT_W'(m_op);
    case (step)
      2'd0:    part_sh = P_W'(part);
      2'd1:    part_sh = P_W'(part) << MLO_W;
      2'd2:    part_sh = P_W'(part) << NLO_W;
      default: part_sh = P_W'(part) << (NLO_W + MLO_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == 2'd3);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + part_sh;
    end
  end

  assign quotient = tmf_pkg::MEAN_W'(acc >> SHIFT);
endmodule

/* hw/rtl/trimmed_mean_filter.sv */
// Trimmed mean filter: samples are written to the store at one per cycle while a running sum of
// the kept samples builds up. After the last sample of a batch the input stalls while 2*TRIM_COUNT
// sweeps over the kept entries, each reading the store through its single read port, find and
// mark the smallest and largest entries and take them off the sum; a reciprocal multiply by the
// fixed count of samples left then forms the mean. The result sits in an output register, and
// the next batch may flow in while it waits to be taken.
module trimmed_mean_filter #(
  parameter int BATCH_SIZE = tmf_pkg::BATCH_SIZE_DEF,
  parameter int SKIP_COUNT = tmf_pkg::SKIP_COUNT_DEF,
  parameter int TRIM_COUNT = tmf_pkg::TRIM_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tmf_pkg::SAMPLE_W-1:0] sample_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tmf_pkg::MEAN_W-1:0]  mean_value
);
  localparam int AW       = $clog2(BATCH_SIZE);
  localparam int LEFT     = BATCH_SIZE - SKIP_COUNT - 2 * TRIM_COUNT;
  localparam bit LEFT_POS = (LEFT > 0);
  localparam int DIVISOR  = LEFT_POS ? LEFT : 1;
  localparam int PW       = $clog2(2 * TRIM_COUNT + 2);

  tmf_pkg::state_t state, state_next;

  logic [AW-1:0]                count;
  logic [AW-1:0]                ra;
  logic [AW-1:0]                ra_q;
  logic                         rv;
  logic [PW-1:0]                pass;
  logic [tmf_pkg::SUM_W-1:0]    sum;
  logic [tmf_pkg::SAMPLE_W-1:0] best_val;
  logic [AW-1:0]                best_addr;
  logic                         found;

  logic                         accept;
  logic                         last;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [tmf_pkg::STORE_W-1:0]  wdata;
  logic [tmf_pkg::STORE_W-1:0]  rdata;
  logic                         is_max;
  logic                         better;
  logic                         div_start;
  logic                         div_done;
  logic [tmf_pkg::MEAN_W-1:0]   quotient;

  assign in_stall = (state != tmf_pkg::S_IN);
  assign accept   = in_valid && !in_stall;
  assign last     = (count == AW'(BATCH_SIZE - 1));
  assign is_max   = (int'(pass) >= TRIM_COUNT);

  always_comb begin
    if (state == tmf_pkg::S_MARK) begin
      we    = 1'b1;
      waddr = best_addr;
      wdata = {1'b1, best_val};
    end else begin
      we    = accept;
      waddr = count;
      wdata = {1'b0, sample_value};
    end
  end

  // unmarked entry wins if none is held yet or it is strictly better; ties keep the first one seen
  always_comb begin
    if (rdata[tmf_pkg::SAMPLE_W]) begin
      better = 1'b0;
    end else if (!found) begin
      better = 1'b1;
    end else if (is_max) begin
      better = rdata[tmf_pkg::SAMPLE_W-1:0] > best_val;
    end else begin
      better = rdata[tmf_pkg::SAMPLE_W-1:0] < best_val;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      tmf_pkg::S_IN: begin
        if (accept && last) begin
          if (LEFT_POS && TRIM_COUNT > 0) begin
            state_next = tmf_pkg::S_SWEEP;
          end else begin
            state_next = tmf_pkg::S_DIV;
            div_start  = 1'b1;
          end
        end
      end
      tmf_pkg::S_SWEEP: begin
        if (ra == AW'(BATCH_SIZE - 1)) begin
          state_next = tmf_pkg::S_LAST;
        end
      end
      tmf_pkg::S_LAST: state_next = tmf_pkg::S_MARK;
      tmf_pkg::S_MARK: begin
        if (int'(pass) == 2 * TRIM_COUNT - 1) begin
          state_next = tmf_pkg::S_DIV;
          div_start  = 1'b1;
        end else begin
          state_next = tmf_pkg::S_SWEEP;
        end
      end
      tmf_pkg::S_DIV: begin
        if (div_done) begin
          state_next = tmf_pkg::S_WAIT;
        end
      end
      tmf_pkg::S_WAIT: begin
        if (!out_valid || !out_stall) begin
          state_next = tmf_pkg::S_IN;
        end
      end
      default: state_next = tmf_pkg::S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmf_pkg::S_IN;
      count     <= '0;
      rv        <= 1'b0;
      pass      <= '0;
      sum       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == tmf_pkg::S_SWEEP);
      if (state == tmf_pkg::S_WAIT && state_next == tmf_pkg::S_IN) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        count <= last ? '0 : count + AW'(1);
      end
      if (div_start) begin
        sum <= '0;
      end else if (state == tmf_pkg::S_MARK) begin
        sum <= sum - tmf_pkg::SUM_W'(best_val);
      end else if (accept && int'(count) >= SKIP_COUNT) begin
        sum <= sum + tmf_pkg::SUM_W'(sample_value);
      end
      if (state == tmf_pkg::S_MARK) begin
        found <= 1'b0;
      end else if (rv && better) begin
        found <= 1'b1;
      end
      if (div_start) begin
        pass <= '0;
      end else if (state == tmf_pkg::S_MARK) begin
        pass <= pass + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_q <= ra;
    if (state == tmf_pkg::S_SWEEP) begin
      ra <= ra + AW'(1);
    end else begin
      ra <= AW'(SKIP_COUNT);
    end
    if (rv && better) begin
      best_val  <= rdata[tmf_pkg::SAMPLE_W-1:0];
      best_addr <= ra_q;
    end
    if (state == tmf_pkg::S_WAIT && state_next == tmf_pkg::S_IN) begin
      mean_value <= quotient;
    end
  end

  tmf_mem #(
    .DEPTH (BATCH_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra),
    .rdata (rdata)
  );

  // the sum does not yet hold the last sample when the divide starts from S_IN
  logic [tmf_pkg::SUM_W-1:0] div_sum;
  assign div_sum = !LEFT_POS ? '0 :
                   (state == tmf_pkg::S_IN && int'(count) >= SKIP_COUNT) ?
                   sum + tmf_pkg::SUM_W'(sample_value) :
                   (state == tmf_pkg::S_MARK) ? sum - tmf_pkg::SUM_W'(best_val) : sum;

  tmf_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({div_sum, tmf_pkg::FRAC_W'(0)}),
    .done     (div_done),
    .quotient (quotient)
  );
endmodule

/* hw/rtl/tmf_checker.sv */
// Port-level checker for the trimmed mean filter, bound to the top level
`include "trimmed_mean_filter_assert.svh"
module tmf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tmf_pkg::MEAN_W-1:0]   mean_value
);
  `TMF_CHECK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `TMF_CHECK(a_out_stable, out_valid && out_stall |=> $stable(mean_value), "result changed")
  `TMF_CHECK(a_rise_after_busy, $rose(out_valid) |-> $past(in_stall), "result without work")
  `TMF_CHECK_ALWAYS(a_reset, rst |=> !out_valid && !in_stall, "bad state after reset")
endmodule

bind trimmed_mean_filter tmf_checker u_tmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .mean_value (mean_value)
);
